// ===== sv/rhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsl_pkg
// Types, constants and the long division step shared by the RGB to HSL
// pipeline.
// ----------------------------------------------------------------------------
package rhsl_pkg;

    localparam int CH_W       = 8;
    localparam int FRAC_W     = 16;
    localparam int DEN_W      = 11;
    localparam int DIV_STAGES = FRAC_W / 2;
    localparam int PIPE_DEPTH = 2 + DIV_STAGES;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        logic [1:0]      sel;
    } mm_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [FRAC_W-1:0] dvd;
        logic [FRAC_W-1:0] quo;
        logic [DEN_W-1:0]  den;
    } div_t;

    typedef struct packed {
        div_t              hue;
        div_t              sat;
        logic [FRAC_W-1:0] lightness;
    } prep_t;

    // two restoring quotient bits per call
    function automatic div_t div_step(div_t cur);
        div_t             nxt;
        logic [DEN_W:0]   part;
        logic [DEN_W-1:0] rem;
        logic [1:0]       qb;
        rem  = cur.rem;
        part = {rem, cur.dvd[FRAC_W-1]};
        if (part >= {1'b0, cur.den})
        begin
            part  = part - {1'b0, cur.den};
            qb[1] = 1'b1;
        end
        else
        begin
            qb[1] = 1'b0;
        end
        rem  = part[DEN_W-1:0];
        part = {rem, cur.dvd[FRAC_W-2]};
        if (part >= {1'b0, cur.den})
        begin
            part  = part - {1'b0, cur.den};
            qb[0] = 1'b1;
        end
        else
        begin
            qb[0] = 1'b0;
        end
        nxt.rem = part[DEN_W-1:0];
        nxt.dvd = {cur.dvd[FRAC_W-3:0], 2'b00};
        nxt.quo = {cur.quo[FRAC_W-3:0], qb};
        nxt.den = cur.den;
        return nxt;
    endfunction

endpackage

// ===== sv/rhsl_minmax.sv =====
// ----------------------------------------------------------------------------
// rhsl_minmax
// First stage: largest and smallest channel and which channel holds the
// maximum, red winning ties, then green.
// ----------------------------------------------------------------------------
module rhsl_minmax
    import rhsl_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  rgb_t din,
    output mm_t  dout
);

    mm_t mm_next;
    mm_t mm_reg;

    always_comb
    begin
        mm_next.red   = din.red;
        mm_next.green = din.green;
        mm_next.blue  = din.blue;
        if (din.red >= din.green && din.red >= din.blue)
        begin
            mm_next.sel = SEL_RED;
            mm_next.mx  = din.red;
        end
        else if (din.green >= din.blue)
        begin
            mm_next.sel = SEL_GREEN;
            mm_next.mx  = din.green;
        end
        else
        begin
            mm_next.sel = SEL_BLUE;
            mm_next.mx  = din.blue;
        end
        if (din.red <= din.green && din.red <= din.blue)
            mm_next.mn = din.red;
        else if (din.green <= din.blue)
            mm_next.mn = din.green;
        else
            mm_next.mn = din.blue;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mm_reg <= mm_next;
    end

    assign dout = mm_reg;

endmodule

// ===== sv/rhsl_prep.sv =====
// ----------------------------------------------------------------------------
// rhsl_prep
// Second stage: lightness, hue and saturation numerators and divisors, and
// the scaled dividends that enter the two dividers.
// ----------------------------------------------------------------------------
module rhsl_prep
    import rhsl_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  mm_t   din,
    output prep_t dout
);

    localparam int DVD_W = DEN_W + FRAC_W;

    logic [CH_W-1:0]   d;
    logic [CH_W:0]     s;
    logic [DEN_W-1:0]  d_x;
    logic [DEN_W-1:0]  hue_num;
    logic [DEN_W-1:0]  hue_den;
    logic [DEN_W-1:0]  sat_num;
    logic [DEN_W-1:0]  sat_den;
    logic [DVD_W-1:0]  hue_x;
    logic [DVD_W-1:0]  sat_x;
    logic [FRAC_W:0]   lig_wide;
    prep_t             prep_next;
    prep_t             prep_reg;

    always_comb
    begin
        d        = din.mx - din.mn;
        s        = {1'b0, din.mx} + {1'b0, din.mn};
        d_x      = {{(DEN_W-CH_W){1'b0}}, d};
        // 65535/510 is exactly 257/2
        lig_wide = {s, 8'b0} + {{(FRAC_W-CH_W){1'b0}}, s};

        unique case (din.sel)
            SEL_RED:
            begin
                if (din.green >= din.blue)
                    hue_num = {3'b0, din.green} - {3'b0, din.blue};
                else
                    hue_num = (d_x << 2) + (d_x << 1) - ({3'b0, din.blue} - {3'b0, din.green});
            end
            SEL_GREEN:
                hue_num = (d_x << 1) + {3'b0, din.blue} - {3'b0, din.red};
            default:
                hue_num = (d_x << 2) + {3'b0, din.red} - {3'b0, din.green};
        endcase

        hue_den = (d_x << 2) + (d_x << 1);
        sat_num = d_x;
        if (s < 9'd255)
            sat_den = {2'b0, s};
        else
            sat_den = {2'b0, 9'd510 - s};

        // gray: zero over one gives a zero quotient
        if (d == '0)
        begin
            hue_num = '0;
            hue_den = DEN_W'(1);
            sat_num = '0;
            sat_den = DEN_W'(1);
        end

        hue_x = {hue_num, {(FRAC_W){1'b0}}} - {{(FRAC_W){1'b0}}, hue_num};
        sat_x = {sat_num, {(FRAC_W){1'b0}}} - {{(FRAC_W){1'b0}}, sat_num};

        prep_next.hue.rem   = hue_x[DVD_W-1:FRAC_W];
        prep_next.hue.dvd   = hue_x[FRAC_W-1:0];
        prep_next.hue.quo   = '0;
        prep_next.hue.den   = hue_den;
        prep_next.sat.rem   = sat_x[DVD_W-1:FRAC_W];
        prep_next.sat.dvd   = sat_x[FRAC_W-1:0];
        prep_next.sat.quo   = '0;
        prep_next.sat.den   = sat_den;
        prep_next.lightness = lig_wide[FRAC_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    assign dout = prep_reg;

endmodule

// ===== sv/rhsl_divider.sv =====
// ----------------------------------------------------------------------------
// rhsl_divider
// Pipelined restoring divider, two quotient bits per stage, one enable per
// stage so that bubbles close up under a stall.
// ----------------------------------------------------------------------------
module rhsl_divider
    import rhsl_pkg::*;
(
    input  logic                   clk,
    input  logic [DIV_STAGES-1:0]  en,
    input  div_t                   din,
    output logic [FRAC_W-1:0]      quo
);

    div_t stage_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
            stage_reg[0] <= div_step(din);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (en[k])
                stage_reg[k] <= div_step(stage_reg[k-1]);
        end
    end

    assign quo = stage_reg[DIV_STAGES-1].quo;

endmodule

// ===== sv/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// RGB pixel to hue, saturation and lightness, 16-bit fractions, truncated.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  pixel   | pixel_valid/pixel_stall | rgb_t : red, green, blue
//  hsl     | hsl_valid/hsl_stall     | hsl_t : hue, saturation, lightness
//
//  Stages: min/max, prepare, then 8 divider stages of 2 bits each.
//  One pixel per cycle sustained while hsl_stall is low; the divider stage count sets the latency.
//  Reset clears the stage valid bits only.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  close up and the input keeps accepting while a result waits.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter
    import rhsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_stall,
    input  rgb_t pixel,
    output logic hsl_valid,
    input  logic hsl_stall,
    output hsl_t hsl
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] rdy;
    logic [FRAC_W-1:0]     lig_reg [DIV_STAGES];
    mm_t                   mm;
    prep_t                 prep;
    logic [FRAC_W-1:0]     hue_q;
    logic [FRAC_W-1:0]     sat_q;

    always_comb
    begin
        rdy[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !hsl_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
        valid_next = valid_reg;
        if (rdy[0])
            valid_next[0] = pixel_valid;
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            if (rdy[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    rhsl_minmax u_minmax
    (
        .clk  (clk),
        .en   (rdy[0]),
        .din  (pixel),
        .dout (mm)
    );

    rhsl_prep u_prep
    (
        .clk  (clk),
        .en   (rdy[1]),
        .din  (mm),
        .dout (prep)
    );

    rhsl_divider u_div_hue
    (
        .clk (clk),
        .en  (rdy[PIPE_DEPTH-1:2]),
        .din (prep.hue),
        .quo (hue_q)
    );

    rhsl_divider u_div_sat
    (
        .clk (clk),
        .en  (rdy[PIPE_DEPTH-1:2]),
        .din (prep.sat),
        .quo (sat_q)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[2])
            lig_reg[0] <= prep.lightness;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (rdy[k+2])
                lig_reg[k] <= lig_reg[k-1];
        end
    end

    assign pixel_stall    = !rdy[0];
    assign hsl_valid      = valid_reg[PIPE_DEPTH-1];
    assign hsl.hue        = hue_q;
    assign hsl.saturation = sat_q;
    assign hsl.lightness  = lig_reg[DIV_STAGES-1];

    // input only backs up when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (valid_reg == '1 && hsl_stall))
        else $error("input stalled with room in the pipeline");

    // black and white pixels are gray
    a_gray_ends: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && (hsl.lightness == '0 || hsl.lightness == '1)
        |-> (hsl.saturation == '0 && hsl.hue == '0))
        else $error("black or white pixel with nonzero hue or saturation");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && !hsl_stall && !valid_reg[PIPE_DEPTH-2] |=> !hsl_valid)
        else $error("result repeated after transaction");

    // a full pipeline under output stall holds every item
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg == '1 && hsl_stall |=> valid_reg == '1)
        else $error("item lost while stalled");

endmodule

// ===== sim/rgb_to_hsl_converter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_test
// Sends directed and random RGB pixels through the converter. Expected hue,
// saturation and lightness are worked out in exact integer arithmetic as each
// pixel transaction is accepted. Each result transaction is checked in order.
// Sender gaps and receiver stalls vary from phase to phase. One long stall
// fills the pipeline so that its input stalls as well.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_test
    import rhsl_pkg::*;
();

    localparam int RANDOM_PER_PHASE = 110;
    localparam int BURST_PIXELS     = 60;
    localparam int HOLD_CYCLES      = 250;
    localparam int MAX_REPORTS      = 10;

    class hsl_tracker;
        hsl_t hsl_due[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [FRAC_W-1:0] frac16(int unsigned num, int unsigned den);
            longint unsigned q;
            if (den == 0)
            begin
                return '0;
            end
            q = (longint'(num) * 65535) / den;
            return q[FRAC_W-1:0];
        endfunction

        static function hsl_t rgb_to_hsl(rgb_t p);
            int unsigned r, g, b, hi, lo, d, s, n;
            hsl_t o;
            r  = 32'(p.red);
            g  = 32'(p.green);
            b  = 32'(p.blue);
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            d  = hi - lo;
            s  = hi + lo;
            o.lightness  = frac16(s, 510);
            o.hue        = '0;
            o.saturation = '0;
            if (d != 0)
            begin
                o.saturation = (s < 255) ? frac16(d, s) : frac16(d, 510 - s);
                if (r == hi)
                    n = (g >= b) ? g - b : 6 * d - (b - g);
                else if (g == hi)
                    n = 2 * d + b - r;
                else
                    n = 4 * d + r - g;
                o.hue = frac16(n, 6 * d);
            end
            return o;
        endfunction

        function void note_pixel(rgb_t p);
            hsl_due.push_back(rgb_to_hsl(p));
        endfunction

        function void check_hsl(hsl_t got);
            hsl_t want;
            if (hsl_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected hsl transaction: hue %0d sat %0d light %0d",
                             got.hue, got.saturation, got.lightness);
                return;
            end
            want = hsl_due.pop_front();
            if (got.hue !== want.hue || got.saturation !== want.saturation
                || got.lightness !== want.lightness)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("hsl wrong: hue %0d/%0d sat %0d/%0d light %0d/%0d (exp/got)",
                             want.hue, got.hue, want.saturation, got.saturation,
                             want.lightness, got.lightness);
            end
        endfunction
    endclass

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    rgb_t pixel       = '0;
    logic hsl_valid;
    logic hsl_stall   = 1'b0;
    hsl_t hsl;

    hsl_tracker tracker = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    rgb_to_hsl_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .hsl_valid   (hsl_valid),
        .hsl_stall   (hsl_stall),
        .hsl         (hsl)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: check accepted results, then choose the next stall
    always @(posedge clk)
    begin
        if (rst_n && hsl_valid && !hsl_stall)
            tracker.check_hsl(hsl);
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            hsl_stall <= 1'b1;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hsl_stall <= 1'b1;
        end
        else
        begin
            hsl_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send_pixel(input rgb_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (pixel_stall);
        tracker.note_pixel(p);
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        rgb_t p;
        p.red   = r[CH_W-1:0];
        p.green = g[CH_W-1:0];
        p.blue  = b[CH_W-1:0];
        send_pixel(p);
    endtask

    function automatic rgb_t random_pixel();
        rgb_t p;
        p.red   = CH_W'($urandom_range(255));
        p.green = CH_W'($urandom_range(255));
        p.blue  = CH_W'($urandom_range(255));
        case ($urandom_range(7))
            0: begin p.green = p.red; p.blue = p.red; end
            1: p.green = p.red;
            2: p.blue  = p.green;
            3: p.blue  = p.red;
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (tracker.hsl_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, gray, ties and both saturation branches
        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(255, 0, 1);
        send_rgb(200, 10, 199);
        send_rgb(254, 0, 0);
        send_rgb(128, 127, 127);
        send_rgb(127, 127, 0);
        send_rgb(1, 0, 0);
        send_rgb(0, 1, 0);
        send_rgb(0, 0, 1);
        send_rgb(255, 254, 254);
        send_rgb(10, 200, 50);
        send_rgb(30, 60, 220);
        send_rgb(170, 85, 170);
        send_rgb(85, 170, 170);
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_arm <= 1'b1;
        for (int i = 0; i < BURST_PIXELS; i++)
            send_pixel(random_pixel());
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_pixel(random_pixel());
            wait_drained();
        end

        rx_stall_pct = 0;
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.hsl_due.size() == 0)
            $display("rgb_to_hsl_converter: match");
        else
            $display("rgb_to_hsl_converter: mismatch");
        $finish;
    end

    initial
    begin
        #2_400_000;
        $display("rgb_to_hsl_converter: mismatch");
        $finish;
    end

endmodule
